// ===== hw/rtl/crcfd_pkg.sv =====
// Package for the CRC frame check deframer: shared types and constants.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package crcfd_pkg;

    // Reset value of the generator polynomial register (CRC-32, leading one implied).
    localparam logic [31:0] GEN_POLY_RESET = 32'h04C1_1DB7;

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One queued piece of work: an optional data byte and an optional frame status.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] byte_value;
        logic       has_status;
        logic       crc_ok;
    } t_entry;

endpackage

// ===== hw/rtl/crcfd_front.sv =====
// Front end of the CRC frame check deframer: remainder division, CRC holdback
// and byte packing, one bit per transaction. Depends on crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_front import crcfd_pkg::*; #(
    parameter int CRC_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_generator_poly,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_bit,
    input  logic        i_in_frame_end,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_entry      o_push_entry
);

    localparam int FILL_W = $clog2(CRC_WIDTH + 1);

    logic [CRC_WIDTH-1:0] r_rem;
    logic [CRC_WIDTH-1:0] n_rem;
    logic [CRC_WIDTH-1:0] r_hold;
    logic [CRC_WIDTH-1:0] n_hold;
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic [7:0]           r_acc;
    logic [7:0]           n_acc;
    logic [2:0]           r_cnt;
    logic [2:0]           n_cnt;
    logic [CRC_WIDTH-1:0] w_poly;
    logic [CRC_WIDTH-1:0] w_div;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_byte_done;
    logic [7:0]           w_byte;

    // Fit the 32-bit register to CRC_WIDTH: upper bits dropped or zero-extended.
    generate
        if (CRC_WIDTH <= 32) begin : g_poly_narrow
            assign w_poly = i_generator_poly[CRC_WIDTH-1:0];
        end else begin : g_poly_wide
            assign w_poly = {{(CRC_WIDTH - 32){1'b0}}, i_generator_poly};
        end
    endgenerate

    // A bit is taken whenever the queue has room for what it may cause.
    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;

    // One division step and the holdback/byte bookkeeping for the incoming bit.
    always_comb begin
        w_div       = r_rem[CRC_WIDTH-1] ? w_poly : '0;
        n_rem       = {r_rem[CRC_WIDTH-2:0], i_in_bit} ^ w_div;
        n_hold      = {r_hold[CRC_WIDTH-2:0], i_in_bit};
        w_full      = (r_fill == FILL_W'(CRC_WIDTH));
        w_byte      = {r_acc[6:0], r_hold[CRC_WIDTH-1]};
        w_byte_done = 1'b0;
        n_fill      = r_fill;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        if (w_full) begin
            n_acc = w_byte;
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                w_byte_done = 1'b1;
                n_acc       = '0;
                n_cnt       = '0;
            end
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // Work handed to the back end; the partial byte at frame end is dropped.
    always_comb begin
        o_push                  = w_accept && (w_byte_done || i_in_frame_end);
        o_push_entry.has_byte   = w_byte_done;
        o_push_entry.byte_value = w_byte;
        o_push_entry.has_status = i_in_frame_end;
        o_push_entry.crc_ok     = (n_rem == '0);
    end

    // Frame state; everything returns to zero at the end of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_hold <= '0;
            r_fill <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            if (i_in_frame_end) begin
                r_rem  <= '0;
                r_hold <= '0;
                r_fill <= '0;
                r_acc  <= '0;
                r_cnt  <= '0;
            end else begin
                r_rem  <= n_rem;
                r_hold <= n_hold;
                r_fill <= n_fill;
                r_acc  <= n_acc;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

// ===== hw/rtl/crcfd_queue.sv =====
// Short queue of work entries between the deframer front and back ends.
// Depends on crcfd_pkg for the entry type.
`timescale 1ns / 1ps

module crcfd_queue import crcfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_entry,
    output logic   o_full,
    output logic   o_not_empty,
    output t_entry o_head,
    input  logic   i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Pointers and occupancy; DEPTH is a power of two so pointers wrap freely.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/crcfd_back.sv =====
// Back end of the CRC frame check deframer: splits queued entries into byte and
// status results and holds them in the output register. Depends on crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_back import crcfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_not_empty,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_byte_value,
    output logic       o_crc_ok,
    output logic       o_last
);

    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_byte_value;
    logic       r_crc_ok;
    logic       r_last;
    logic       r_phase;
    logic       n_phase;
    logic       w_load;
    logic       n_kind;
    logic [7:0] n_byte_value;
    logic       n_crc_ok;
    logic       n_last;

    // The output register takes a new result whenever it is empty or draining.
    assign w_load = i_not_empty && (!r_out_valid || !i_out_stall);

    // Pick the next result of the head entry: its byte first, then its status.
    always_comb begin
        if (i_head.has_byte && !r_phase) begin
            n_kind       = KIND_DATA;
            n_byte_value = i_head.byte_value;
            n_crc_ok     = 1'b0;
            n_last       = !i_head.has_status;
            n_phase      = i_head.has_status;
        end else begin
            n_kind       = KIND_STATUS;
            n_byte_value = '0;
            n_crc_ok     = i_head.crc_ok;
            n_last       = 1'b1;
            n_phase      = 1'b0;
        end
        o_pop = w_load && n_last;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind       <= n_kind;
            r_byte_value <= n_byte_value;
            r_crc_ok     <= n_crc_ok;
            r_last       <= n_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_byte_value = r_byte_value;
    assign o_crc_ok     = r_crc_ok;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/crc32_frame_check_deframer.sv =====
// Top level of the CRC frame check deframer: generator register, front end,
// work queue and back end. Depends on crcfd_pkg, crcfd_front, crcfd_queue, crcfd_back.
`timescale 1ns / 1ps

// The block takes one frame bit per cycle unless stalled by a full queue (MSB first,
// frame_end on the final bit) and divides the frame by the generator polynomial with
// no initial value, reflection or final XOR. The newest CRC_WIDTH bits are held back
// as the CRC; older bits come out as data bytes, and the frame end gives a status
// result with crc_ok set when the remainder is zero. A partial byte at frame end is
// dropped. Throughput is one bit per cycle while not stalled, set by the shift-and-XOR
// of the remainder; the back end delivers one result per cycle unless the receiver
// stalls, so the status that follows a byte on the same bit is an extra result,
// absorbed by the FIFO_DEPTH-entry queue (a power of two, 2 to 32). A result passes
// through the queue and the output register. The generator register is written
// through the configuration channel, which is always ready; write it only while idle.
module crc32_frame_check_deframer import crcfd_pkg::*; #(
    parameter int CRC_WIDTH  = 32,
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_bit,
    input  logic        i_in_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_crc_ok,
    output logic        o_last
);

    logic [31:0] r_generator_poly;
    logic        w_push;
    t_entry      w_push_entry;
    logic        w_full;
    logic        w_not_empty;
    t_entry      w_head;
    logic        w_pop;

    // Generator polynomial register; a configuration transaction is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_generator_poly <= GEN_POLY_RESET;
        end else if (i_cfg_valid) begin
            r_generator_poly <= i_cfg_data;
        end
    end

    crcfd_front #(
        .CRC_WIDTH (CRC_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_generator_poly (r_generator_poly),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_bit         (i_in_bit),
        .i_in_frame_end   (i_in_frame_end),
        .i_queue_full     (w_full),
        .o_push           (w_push),
        .o_push_entry     (w_push_entry)
    );

    crcfd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .o_full       (w_full),
        .o_not_empty  (w_not_empty),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    crcfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_not_empty  (w_not_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_byte_value (o_byte_value),
        .o_crc_ok     (o_crc_ok),
        .o_last       (o_last)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for crc32_frame_check_deframer: frames of serial bits in,
// data bytes and CRC status out, checked against a bit-level predictor.
// Depends on crcfd_pkg and crc32_frame_check_deframer.
`timescale 1ns / 1ps

module tb_top;
    import crcfd_pkg::*;

    localparam int CRC_W      = 32;
    localparam int PHASE_BITS = 360;
    localparam int TAIL_CYCLES = 8;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       crc_ok;
        logic       last;
    } t_result;

    // Scoreboard: tracks the division and delay line of the block and holds
    // the results that the accepted bits are due to produce.
    class deframe_scoreboard;
        logic [31:0]      poly;
        logic [CRC_W-1:0] remainder;
        logic [CRC_W-1:0] holdback;
        int               hold_fill;
        logic [7:0]       byte_acc;
        int               acc_bits;
        t_result          due_results[$];
        int               errors;

        function new();
            poly = GEN_POLY_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            remainder = '0;
            holdback = '0;
            hold_fill = 0;
            byte_acc = '0;
            acc_bits = 0;
        endfunction

        function void set_poly(input logic [31:0] value);
            poly = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Called for every accepted input transaction.
        function void shift_in_bit(input logic in_bit, input logic frame_end);
            logic    top;
            t_result r;

            top = remainder[CRC_W-1];
            remainder = {remainder[CRC_W-2:0], in_bit};
            if (top)
                remainder ^= poly[CRC_W-1:0];

            // Once the delay line is full, its oldest bit becomes frame data.
            if (hold_fill >= CRC_W) begin
                byte_acc = {byte_acc[6:0], holdback[CRC_W-1]};
                acc_bits++;
                if (acc_bits == 8) begin
                    r = '{kind: KIND_DATA, byte_value: byte_acc, crc_ok: 1'b0,
                          last: !frame_end};
                    due_results.push_back(r);
                    byte_acc = '0;
                    acc_bits = 0;
                end
            end else begin
                hold_fill++;
            end
            holdback = {holdback[CRC_W-2:0], in_bit};

            if (frame_end) begin
                r = '{kind: KIND_STATUS, byte_value: 8'd0, crc_ok: (remainder == '0),
                      last: 1'b1};
                due_results.push_back(r);
                clear_frame();
            end
        endfunction

        // Called for every accepted output transaction.
        function void check_result(input logic kind, input logic [7:0] byte_value,
                                   input logic crc_ok, input logic last);
            t_result exp_r;

            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d byte 0x%02h crc_ok %0d last %0d",
                       kind, byte_value, crc_ok, last);
                errors++;
                return;
            end
            exp_r = due_results.pop_front();
            if (kind !== exp_r.kind) begin
                $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                errors++;
            end
            if (byte_value !== exp_r.byte_value) begin
                $error("byte_value: expected 0x%02h, got 0x%02h", exp_r.byte_value,
                       byte_value);
                errors++;
            end
            if (crc_ok !== exp_r.crc_ok) begin
                $error("crc_ok: expected %0d, got %0d", exp_r.crc_ok, crc_ok);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last: expected %0d, got %0d", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_bit = 1'b0;
    logic        in_frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic        out_crc_ok;
    logic        out_last;

    // When set, neither side idles.
    logic        calm = 1'b0;

    deframe_scoreboard board;
    logic              frame_q[$];

    crc32_frame_check_deframer #(
        .CRC_WIDTH(CRC_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_bit      (in_bit),
        .i_in_frame_end(in_frame_end),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (out_kind),
        .o_byte_value  (out_byte),
        .o_crc_ok      (out_crc_ok),
        .o_last        (out_last)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall, driven at the falling edge.
    always @(negedge i_clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    // Check every accepted output transaction.
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_kind, out_byte, out_crc_ok, out_last);
    end

    // Remainder of the frame bits times x^CRC_W, which is the CRC to append.
    function automatic logic [CRC_W-1:0] frame_crc(input logic bits[$],
                                                   input logic [31:0] poly);
        logic [CRC_W-1:0] r;
        logic             top;
        int               k;

        r = '0;
        for (k = 0; k < bits.size() + CRC_W; k++) begin
            top = r[CRC_W-1];
            r = {r[CRC_W-2:0], (k < bits.size()) ? bits[k] : 1'b0};
            if (top)
                r ^= poly[CRC_W-1:0];
        end
        return r;
    endfunction

    // Send one bit; the sender may idle first.
    task automatic send_bit(input logic b, input logic e);
        while (!calm && $urandom_range(0, 99) < 31) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_bit <= b;
        in_frame_end <= e;
        do @(posedge i_clk); while (in_stall);
        board.shift_in_bit(b, e);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_bit(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Lower valid and wait until every expected result has come, plus a margin
    // for bits that are still in flight without a result.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_poly(input logic [31:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        board.set_poly(value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Build a random frame: mostly data with a correct CRC, some with one bit
    // flipped, some plain noise.
    task automatic build_frame(input logic [31:0] poly);
        int               pick;
        int               len;
        int               k;
        logic [CRC_W-1:0] crc;

        frame_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            len = $urandom_range(1, 70);
            for (k = 0; k < len; k++)
                frame_q.push_back(1'($urandom_range(0, 1)));
        end else begin
            len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 48);
            for (k = 0; k < len; k++)
                frame_q.push_back(1'($urandom_range(0, 1)));
            crc = frame_crc(frame_q, poly);
            for (k = CRC_W - 1; k >= 0; k--)
                frame_q.push_back(crc[k]);
            if (pick < 30) begin
                k = $urandom_range(0, frame_q.size() - 1);
                frame_q[k] = !frame_q[k];
            end
        end
    endtask

    // Main sequence.
    initial begin
        logic [31:0] polys[5];
        int          sent;
        int          frames;
        int          k;

        board = new();
        polys[0] = GEN_POLY_RESET;
        polys[1] = 32'hFFFF_FFFF;
        polys[2] = 32'h0000_0000;
        polys[3] = $urandom;
        polys[4] = GEN_POLY_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        write_poly(polys[0]);

        // Directed frames: single one, single zero, a byte of ones, alternating bits.
        frame_q = '{1'b1};
        send_frame();
        frame_q = '{1'b0};
        send_frame();
        frame_q.delete();
        for (k = 0; k < 8; k++)
            frame_q.push_back(1'b1);
        send_frame();
        frame_q.delete();
        for (k = 0; k < 12; k++)
            frame_q.push_back(k[0]);
        send_frame();
        drain();

        // Random phases, one generator setting each; the second runs without idling.
        for (int p = 0; p < 5; p++) begin
            if (p > 0)
                write_poly(polys[p]);
            calm = (p == 1);
            sent = 0;
            frames = 0;
            while (sent < PHASE_BITS) begin
                build_frame(polys[p]);
                send_frame();
                sent += frame_q.size();
                frames++;
                // Let the sender hold off until the output side has caught up.
                if (frames == 3 || $urandom_range(0, 7) == 0)
                    drain();
            end
            drain();
        end
        calm = 1'b0;

        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/crcfd_pkg.sv
hw/rtl/crcfd_front.sv
hw/rtl/crcfd_queue.sv
hw/rtl/crcfd_back.sv
hw/rtl/crc32_frame_check_deframer.sv
bench/tb_top.sv
